@@ design/btpc_pkg.sv @@
// btpc_pkg: shared widths, codes and payload types of the barometric compensation core
// no dependencies; used by the channel interfaces and every design module
package btpc_pkg;

   localparam int RAW_W        = 20;
   localparam int CAL_W        = 48;
   localparam int CSR_IDX_W    = 2;
   localparam int TEMP_W       = 16;
   localparam int PRESS_W      = 25;
   localparam int QUOT_W       = 36;
   localparam int DIV_W        = 40;
   localparam int DIVD_W       = 75;
   localparam int FRONT_STAGES = 12;
   localparam int BACK_STAGES  = 4;

   localparam logic [QUOT_W-1:0]  QUOT_LIMIT  = QUOT_W'(64'd34359738368);
   localparam logic [PRESS_W-1:0] PRESS_MAX   = '1;
   localparam int                 PRESS_SCALE = 3125;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CALIB_TEMPERATURE   = 2'd0,
      CSR_CALIB_PRESSURE_LOW  = 2'd1,
      CSR_CALIB_PRESSURE_MID  = 2'd2,
      CSR_CALIB_PRESSURE_HIGH = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic        [15:0] t1;
      logic signed [15:0] t2;
      logic signed [15:0] t3;
      logic        [15:0] p1;
      logic signed [15:0] p2;
      logic signed [15:0] p3;
      logic signed [15:0] p4;
      logic signed [15:0] p5;
      logic signed [15:0] p6;
      logic signed [15:0] p7;
      logic signed [15:0] p8;
      logic signed [15:0] p9;
   } calib_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temp;
      logic                     zero;
      logic                     neg;
      logic                     sat;
      logic [DIV_W-1:0]         y;
      logic [DIV_W-1:0]         r;
      logic [QUOT_W-1:0]        x;
      logic [QUOT_W-1:0]        q;
   } div_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temperature_centi;
      logic [PRESS_W-1:0]       pressure_q24_8;
      logic                     pressure_invalid;
   } result_type;

endpackage

@@ design/btpc_if.sv @@
// btpc_if: request, response and register-write channel interfaces
// depends on btpc_pkg for field widths
interface btpc_req_if;
   import btpc_pkg::*;
   logic             valid;
   logic             ready;
   logic [RAW_W-1:0] raw_temperature;
   logic [RAW_W-1:0] raw_pressure;
   modport source (output valid, output raw_temperature, output raw_pressure, input ready);
   modport sink (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

interface btpc_rsp_if;
   import btpc_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [TEMP_W-1:0] temperature_centi;
   logic [PRESS_W-1:0]       pressure_q24_8;
   logic                     pressure_invalid;
   modport source (output valid, output temperature_centi, output pressure_q24_8,
                   output pressure_invalid, input ready);
   modport sink (input valid, input temperature_centi, input pressure_q24_8,
                 input pressure_invalid, output ready);
endinterface

interface btpc_csr_if;
   import btpc_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CAL_W-1:0]     data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/baro_temp_pressure_compensation_core.sv @@
// baro_temp_pressure_compensation_core: top level with calibration registers and output stage
// depends on btpc_pkg, btpc_if, btpc_front, btpc_div and btpc_back
// throughput: one reading per cycle while the skid register is empty; most of the depth is the 36-stage divider
// a response held at the output still lets requests in until the skid register fills
// reset empties the pipeline and clears all calibration registers to zero
module baro_temp_pressure_compensation_core (
   input  logic        clock,
   input  logic        reset,
   btpc_req_if.sink    req_ch,
   btpc_rsp_if.source  rsp_ch,
   btpc_csr_if.sink    csr_ch
);
   import btpc_pkg::*;

   logic [CAL_W-1:0] calib_temperature_ff;
   logic [CAL_W-1:0] calib_pressure_low_ff;
   logic [CAL_W-1:0] calib_pressure_mid_ff;
   logic [CAL_W-1:0] calib_pressure_high_ff;
   calib_type        calib;

   logic       adv;
   logic       front_valid, div_valid, pipe_valid;
   div_type    front_item, div_item;
   result_type pipe_result;
   result_type out_ff, skid_ff;
   logic       out_v_ff, skid_v_ff;
   logic       out_free;

   // calibration writes
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         calib_temperature_ff   <= '0;
         calib_pressure_low_ff  <= '0;
         calib_pressure_mid_ff  <= '0;
         calib_pressure_high_ff <= '0;
      end else if (csr_ch.valid) begin
         unique case (csr_index_type'(csr_ch.index))
            CSR_CALIB_TEMPERATURE:   calib_temperature_ff   <= csr_ch.data;
            CSR_CALIB_PRESSURE_LOW:  calib_pressure_low_ff  <= csr_ch.data;
            CSR_CALIB_PRESSURE_MID:  calib_pressure_mid_ff  <= csr_ch.data;
            CSR_CALIB_PRESSURE_HIGH: calib_pressure_high_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   assign calib.t1 = calib_temperature_ff[15:0];
   assign calib.t2 = calib_temperature_ff[31:16];
   assign calib.t3 = calib_temperature_ff[47:32];
   assign calib.p1 = calib_pressure_low_ff[15:0];
   assign calib.p2 = calib_pressure_low_ff[31:16];
   assign calib.p3 = calib_pressure_low_ff[47:32];
   assign calib.p4 = calib_pressure_mid_ff[15:0];
   assign calib.p5 = calib_pressure_mid_ff[31:16];
   assign calib.p6 = calib_pressure_mid_ff[47:32];
   assign calib.p7 = calib_pressure_high_ff[15:0];
   assign calib.p8 = calib_pressure_high_ff[31:16];
   assign calib.p9 = calib_pressure_high_ff[47:32];

   // pipeline
   assign adv          = !skid_v_ff;
   assign req_ch.ready = adv;

   btpc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .adv             (adv),
      .in_valid        (req_ch.valid),
      .raw_temperature (req_ch.raw_temperature),
      .raw_pressure    (req_ch.raw_pressure),
      .calib           (calib),
      .out_valid       (front_valid),
      .out_item        (front_item)
   );

   btpc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (front_valid),
      .in_item   (front_item),
      .out_valid (div_valid),
      .out_item  (div_item)
   );

   btpc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (div_valid),
      .in_item    (div_item),
      .calib      (calib),
      .out_valid  (pipe_valid),
      .out_result (pipe_result)
   );

   // output register with skid
   assign out_free = !out_v_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_v_ff) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            out_v_ff <= pipe_valid;
         end
      end else if (pipe_valid && adv) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_ff <= skid_v_ff ? skid_ff : pipe_result;
      end else if (adv) begin
         skid_ff <= pipe_result;
      end
   end

   assign rsp_ch.valid             = out_v_ff;
   assign rsp_ch.temperature_centi = out_ff.temperature_centi;
   assign rsp_ch.pressure_q24_8    = out_ff.pressure_q24_8;
   assign rsp_ch.pressure_invalid  = out_ff.pressure_invalid;

endmodule

@@ design/btpc_front.sv @@
// btpc_front: temperature compensation and pressure terms up to the divider operands
// depends on btpc_pkg; twelve register stages, all advanced by one enable
module btpc_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         in_valid,
   input  logic [btpc_pkg::RAW_W-1:0]   raw_temperature,
   input  logic [btpc_pkg::RAW_W-1:0]   raw_pressure,
   input  btpc_pkg::calib_type          calib,
   output logic                         out_valid,
   output btpc_pkg::div_type            out_item
);
   import btpc_pkg::*;

   logic [FRONT_STAGES-1:0] vld_ff;

   logic signed [17:0] d1_in, d1_ff;
   logic signed [16:0] dt_in, dt_ff;
   logic [RAW_W-1:0]   rp1_ff, rp2_ff, rp3_ff, rp4_ff, rp5_ff, rp6_ff, rp7_ff, rp8_ff;
   logic signed [33:0] pa_in, pa_ff, dd_in, dd_ff;
   logic signed [22:0] at_in, at_ff;
   logic signed [37:0] bt_in, bt_ff;
   logic signed [23:0] fine_in, fine_ff;
   logic signed [24:0] e_in, e_ff;
   logic signed [26:0] t5;
   logic signed [18:0] ts;
   logic signed [TEMP_W-1:0] temp_in, temp5_ff, temp6_ff, temp7_ff, temp8_ff, temp9_ff;
   logic signed [TEMP_W-1:0] temp10_ff, temp11_ff;
   logic signed [49:0] ee_in, ee_ff;
   logic signed [40:0] ep5_in, ep5_ff, ep2_in, ep2_ff, ep5_7_ff, ep2_7_ff;
   logic signed [63:0] b1_in, b1_ff, a1_in, a1_ff;
   logic signed [63:0] b_in, b_ff, a_in, a_ff;
   logic signed [63:0] m1_in, m1_ff, num_in, num_ff;
   logic [48:0]        m2_in, m2_ff;
   logic signed [63:0] dv, absd, absn;
   logic [DIV_W-1:0]   y_in, y_ff, y11_ff;
   logic [62:0]        an_in, an_ff;
   logic               neg_in, neg_ff, neg11_ff, zero_in, zero_ff, zero11_ff;
   logic [DIVD_W-1:0]  x_in, x_ff;
   div_type            item_in, item_ff;

   always_comb begin
      // temperature
      d1_in   = $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, calib.t1, 1'b0});
      dt_in   = $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, calib.t1});
      pa_in   = 34'(d1_ff) * 34'($signed(calib.t2));
      dd_in   = 34'(dt_ff) * 34'(dt_ff);
      at_in   = $signed(pa_ff[33:11]);
      bt_in   = 38'($signed(dd_ff[33:12])) * 38'($signed(calib.t3));
      fine_in = 24'(at_ff) + $signed(bt_ff[37:14]);
      e_in    = 25'(fine_ff) - 25'sd128000;
      t5      = (27'(fine_ff) <<< 2) + 27'(fine_ff) + 27'sd128;
      ts      = $signed(t5[26:8]);
      if (ts > 19'sd32767) begin
         temp_in = 16'sh7FFF;
      end else if (ts < -19'sd32768) begin
         temp_in = 16'sh8000;
      end else begin
         temp_in = ts[15:0];
      end
      // pressure offset and scale terms
      ee_in  = 50'(e_ff) * 50'(e_ff);
      ep5_in = 41'(e_ff) * 41'($signed(calib.p5));
      ep2_in = 41'(e_ff) * 41'($signed(calib.p2));
      b1_in  = 64'(ee_ff) * 64'($signed(calib.p6));
      a1_in  = 64'(ee_ff) * 64'($signed(calib.p3));
      b_in   = b1_ff + (64'(ep5_7_ff) <<< 17) + (64'($signed(calib.p4)) <<< 35);
      a_in   = (a1_ff >>> 8) + (64'(ep2_7_ff) <<< 12) + (64'sd1 <<< 47);
      m1_in  = 64'($signed(a_ff[63:33])) * 64'($signed({1'b0, calib.p1}));
      m2_in  = 49'(a_ff[32:0]) * 49'(calib.p1);
      num_in = ((64'sd1048576 - $signed({44'd0, rp8_ff})) <<< 31) - b_ff;
      // divider operands as magnitudes
      dv      = m1_ff + $signed({48'd0, m2_ff[48:33]});
      absd    = dv[63] ? -dv : dv;
      absn    = num_ff[63] ? -num_ff : num_ff;
      y_in    = absd[DIV_W-1:0];
      zero_in = (dv == 64'sd0);
      an_in   = absn[62:0];
      neg_in  = dv[63] ^ num_ff[63];
      x_in    = DIVD_W'(an_ff) * DIVD_W'(PRESS_SCALE);
      item_in.temp = temp11_ff;
      item_in.zero = zero11_ff;
      item_in.neg  = neg11_ff;
      item_in.y    = y11_ff;
      item_in.sat  = ({1'b0, x_ff} >= {y11_ff, QUOT_W'(0)});
      item_in.r    = DIV_W'(x_ff[DIVD_W-1:QUOT_W]);
      item_in.x    = x_ff[QUOT_W-1:0];
      item_in.q    = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[FRONT_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d1_ff     <= d1_in;
         dt_ff     <= dt_in;
         rp1_ff    <= raw_pressure;
         pa_ff     <= pa_in;
         dd_ff     <= dd_in;
         rp2_ff    <= rp1_ff;
         at_ff     <= at_in;
         bt_ff     <= bt_in;
         rp3_ff    <= rp2_ff;
         fine_ff   <= fine_in;
         rp4_ff    <= rp3_ff;
         e_ff      <= e_in;
         temp5_ff  <= temp_in;
         rp5_ff    <= rp4_ff;
         ee_ff     <= ee_in;
         ep5_ff    <= ep5_in;
         ep2_ff    <= ep2_in;
         temp6_ff  <= temp5_ff;
         rp6_ff    <= rp5_ff;
         b1_ff     <= b1_in;
         a1_ff     <= a1_in;
         ep5_7_ff  <= ep5_ff;
         ep2_7_ff  <= ep2_ff;
         temp7_ff  <= temp6_ff;
         rp7_ff    <= rp6_ff;
         b_ff      <= b_in;
         a_ff      <= a_in;
         temp8_ff  <= temp7_ff;
         rp8_ff    <= rp7_ff;
         m1_ff     <= m1_in;
         m2_ff     <= m2_in;
         num_ff    <= num_in;
         temp9_ff  <= temp8_ff;
         y_ff      <= y_in;
         an_ff     <= an_in;
         neg_ff    <= neg_in;
         zero_ff   <= zero_in;
         temp10_ff <= temp9_ff;
         x_ff      <= x_in;
         y11_ff    <= y_ff;
         neg11_ff  <= neg_ff;
         zero11_ff <= zero_ff;
         temp11_ff <= temp10_ff;
         item_ff   <= item_in;
      end
   end

   assign out_valid = vld_ff[FRONT_STAGES-1];
   assign out_item  = item_ff;

endmodule

@@ design/btpc_div.sv @@
// btpc_div: pipelined restoring divider, one quotient bit per stage
// depends on btpc_pkg for the div_type stage payload
module btpc_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  btpc_pkg::div_type in_item,
   output logic              out_valid,
   output btpc_pkg::div_type out_item
);
   import btpc_pkg::*;

   logic [QUOT_W-1:0] vld_ff;
   div_type           stage_ff [QUOT_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[QUOT_W-2:0], in_valid};
      end
   end

   for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
      div_type          src;
      div_type          stage_in;
      logic [DIV_W:0]   rem2;
      logic [DIV_W:0]   diff;

      if (k == 0) begin : g_first
         assign src = in_item;
      end else begin : g_next
         assign src = stage_ff[k-1];
      end

      always_comb begin
         rem2       = {src.r, src.x[QUOT_W-1]};
         diff       = rem2 - {1'b0, src.y};
         stage_in   = src;
         stage_in.x = {src.x[QUOT_W-2:0], 1'b0};
         if (!diff[DIV_W]) begin
            stage_in.r = diff[DIV_W-1:0];
            stage_in.q = {src.q[QUOT_W-2:0], 1'b1};
         end else begin
            stage_in.r = rem2[DIV_W-1:0];
            stage_in.q = {src.q[QUOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            stage_ff[k] <= stage_in;
         end
      end
   end

   assign out_valid = vld_ff[QUOT_W-1];
   assign out_item  = stage_ff[QUOT_W-1];

endmodule

@@ design/btpc_back.sv @@
// btpc_back: quotient clamp, second-order pressure correction and output saturation
// depends on btpc_pkg; four register stages on the shared enable
module btpc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  btpc_pkg::div_type    in_item,
   input  btpc_pkg::calib_type  calib,
   output logic                 out_valid,
   output btpc_pkg::result_type out_result
);
   import btpc_pkg::*;

   logic [BACK_STAGES-1:0]   vld_ff;
   logic [QUOT_W-1:0]        mag;
   logic signed [QUOT_W:0]   p_in, p1_ff, p2_ff, p3_ff;
   logic signed [TEMP_W-1:0] temp1_ff, temp2_ff, temp3_ff;
   logic                     zero1_ff, zero2_ff, zero3_ff;
   logic signed [23:0]       sp;
   logic signed [48:0]       ss_in, ss_ff;
   logic signed [52:0]       k2_in, k2_ff, k2_3_ff;
   logic signed [63:0]       k1_in, k1_ff;
   logic signed [40:0]       sum;
   logic signed [33:0]       press;
   result_type               res_in, res_ff;

   always_comb begin
      if (in_item.sat || (in_item.q > QUOT_LIMIT)) begin
         mag = QUOT_LIMIT;
      end else begin
         mag = in_item.q;
      end
      p_in  = in_item.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      sp    = $signed(p1_ff[QUOT_W:13]);
      ss_in = 49'(sp) * 49'(sp);
      k2_in = 53'(p1_ff) * 53'($signed(calib.p8));
      k1_in = 64'(ss_ff) * 64'($signed(calib.p9));
      sum   = 41'(p3_ff) + 41'($signed(k1_ff[63:25])) + 41'($signed(k2_3_ff[52:19]));
      press = 34'($signed(sum[40:8])) + (34'($signed(calib.p7)) <<< 4);
      res_in.temperature_centi = temp3_ff;
      res_in.pressure_invalid  = zero3_ff;
      if (zero3_ff || press < 34'sd0) begin
         res_in.pressure_q24_8 = '0;
      end else if (press > $signed({9'd0, PRESS_MAX})) begin
         res_in.pressure_q24_8 = PRESS_MAX;
      end else begin
         res_in.pressure_q24_8 = press[PRESS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[BACK_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_ff    <= p_in;
         temp1_ff <= in_item.temp;
         zero1_ff <= in_item.zero;
         ss_ff    <= ss_in;
         k2_ff    <= k2_in;
         p2_ff    <= p1_ff;
         temp2_ff <= temp1_ff;
         zero2_ff <= zero1_ff;
         k1_ff    <= k1_in;
         k2_3_ff  <= k2_ff;
         p3_ff    <= p2_ff;
         temp3_ff <= temp2_ff;
         zero3_ff <= zero2_ff;
         res_ff   <= res_in;
      end
   end

   assign out_valid  = vld_ff[BACK_STAGES-1];
   assign out_result = res_ff;

endmodule
